/* design/tpl_pkg.sv */
// shared types and constants of the triangle point locator
package tpl_pkg;

  localparam logic [1:0] MODE_VERTEX   = 2'd0;
  localparam logic [1:0] MODE_TRIANGLE = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;

  localparam int CROSS_W  = 67;
  localparam int WEIGHT_W = 17;
  localparam int DIV_LAST = 17;
  localparam int MUL_LAST = 9;

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  typedef struct packed {
    logic       wr_vertex;
    logic       wr_triangle;
    logic       load_point;
    logic       clear;
    logic       tri_rd;
    logic       vrd_en;
    logic [1:0] vrd_sel;
    logic       vlatch_en;
    logic [1:0] vlatch_sel;
    logic       mul_issue;
    logic [2:0] mul_step;
    logic       norm;
    logic       div_en;
    logic       div_first;
    logic       div_last;
    logic [1:0] div_sel;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

endpackage

/* design/tpl_ctrl.sv */
// controller: walks the triangles of a query and sequences the datapath
module tpl_ctrl #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int TAW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    mode,
  input  logic          cfg_valid,
  input  logic [10:0]   cfg_data,
  input  tpl_pkg::sts_t sts,
  output tpl_pkg::cmd_t cmd,
  output logic [TAW-1:0] tri_addr,
  output logic          busy,
  output logic          cfg_ready,
  output logic          done,
  output logic          found,
  output logic [9:0]    triangle_index
);
  import tpl_pkg::*;

  localparam int TCW = $clog2(MAX_TRIANGLES + 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_TRI  = 11'b00000000010,
    S_VA   = 11'b00000000100,
    S_VB   = 11'b00000001000,
    S_VC   = 11'b00000010000,
    S_VL   = 11'b00000100000,
    S_MUL  = 11'b00001000000,
    S_NORM = 11'b00010000000,
    S_TEST = 11'b00100000000,
    S_DIV  = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] wsel, wsel_next;
  logic [TCW-1:0] tri_cnt, tri_cnt_next;
  logic found_q, found_q_next;
  logic [10:0] count;
  logic [31:0] limit;
  logic accept;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign done      = (state == S_DONE);
  assign found     = found_q;
  assign triangle_index = found_q ? 10'(tri_cnt) : 10'd0;
  assign tri_addr  = TAW'(tri_cnt);

  // count above the store depth saturates
  assign limit = ({21'd0, count} > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES)
                                                       : {21'd0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      wsel    <= '0;
      tri_cnt <= '0;
      found_q <= 1'b0;
      count   <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      wsel    <= wsel_next;
      tri_cnt <= tri_cnt_next;
      found_q <= found_q_next;
      if (cfg_valid && cfg_ready) count <= cfg_data;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    wsel_next    = wsel;
    tri_cnt_next = tri_cnt;
    found_q_next = found_q;
    cmd          = '0;
    cmd.mul_step = cnt[2:0];
    cmd.div_sel  = wsel;
    case (state)
      S_IDLE: begin
        cmd.wr_vertex   = accept && (mode == MODE_VERTEX);
        cmd.wr_triangle = accept && (mode == MODE_TRIANGLE);
        if (accept && (mode == MODE_QUERY)) begin
          cmd.load_point = 1'b1;
          cmd.clear      = 1'b1;
          tri_cnt_next   = '0;
          found_q_next   = 1'b0;
          state_next     = S_TRI;
        end
      end
      S_TRI: begin
        if (32'(tri_cnt) >= limit) begin
          state_next = S_DONE;
        end else begin
          cmd.tri_rd = 1'b1;
          state_next = S_VA;
        end
      end
      S_VA: begin
        cmd.vrd_en  = 1'b1;
        cmd.vrd_sel = CORNER_A;
        state_next  = S_VB;
      end
      S_VB: begin
        cmd.vrd_en     = 1'b1;
        cmd.vrd_sel    = CORNER_B;
        cmd.vlatch_en  = 1'b1;
        cmd.vlatch_sel = CORNER_A;
        state_next     = S_VC;
      end
      S_VC: begin
        cmd.vrd_en     = 1'b1;
        cmd.vrd_sel    = CORNER_C;
        cmd.vlatch_en  = 1'b1;
        cmd.vlatch_sel = CORNER_B;
        state_next     = S_VL;
      end
      S_VL: begin
        cmd.vlatch_en  = 1'b1;
        cmd.vlatch_sel = CORNER_C;
        cnt_next       = '0;
        state_next     = S_MUL;
      end
      S_MUL: begin
        // eight products, then wait for the multiplier pipe to drain
        cmd.mul_issue = (cnt < 5'd8);
        if (cnt == 5'(MUL_LAST)) begin
          cnt_next   = '0;
          state_next = S_NORM;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_NORM: begin
        cmd.norm   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (sts.hit) begin
          found_q_next = 1'b1;
          cnt_next     = '0;
          wsel_next    = '0;
          state_next   = S_DIV;
        end else begin
          tri_cnt_next = tri_cnt + TCW'(1);
          state_next   = S_TRI;
        end
      end
      S_DIV: begin
        cmd.div_en    = 1'b1;
        cmd.div_first = (cnt == 5'd0);
        cmd.div_last  = (cnt == 5'(DIV_LAST));
        if (cnt == 5'(DIV_LAST)) begin
          cnt_next = '0;
          if (wsel == 2'd2) begin
            state_next = S_DONE;
          end else begin
            wsel_next = wsel + 2'd1;
          end
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/tpl_datapath.sv */
// datapath: stores, shared multiplier, containment test and weight divider
module tpl_datapath #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 1024,
  parameter int TAW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  tpl_pkg::cmd_t       cmd,
  input  logic [TAW-1:0]      tri_addr,
  input  logic [9:0]          slot,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic [9:0]          corner_a,
  input  logic [9:0]          corner_b,
  input  logic [9:0]          corner_c,
  output tpl_pkg::sts_t       sts,
  output logic [16:0]         weight_a,
  output logic [16:0]         weight_b,
  output logic [16:0]         weight_c
);
  import tpl_pkg::*;

  localparam int VAW = $clog2(MAX_VERTICES);

  function automatic logic signed [32:0] dif(logic signed [31:0] a, logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  logic [63:0] vmem [MAX_VERTICES];
  logic [29:0] tmem [MAX_TRIANGLES];

  logic [29:0] tri_q;
  logic [63:0] vert_q;
  logic        oob_q;
  logic [9:0]  corner;
  logic        corner_oob;

  logic signed [31:0] ax, ay, bx, by, cx, cy, px, py;
  logic signed [32:0] op1, op2, d1, d2;
  logic signed [65:0] prod;
  logic signed [CROSS_W-1:0] acc;
  logic signed [CROSS_W-1:0] crs [4];
  logic signed [CROSS_W-1:0] nrm [4];
  logic [2:0] s1, s2;
  logic v1, v2;

  logic [CROSS_W:0] rem, rem_in, rem_sub;
  logic [CROSS_W-1:0] num;
  logic [17:0] q, q_in, q_new;
  logic [18:0] rsum;
  logic ge;
  logic [WEIGHT_W-1:0] w [3];

  always_comb begin
    case (cmd.vrd_sel)
      CORNER_A: corner = tri_q[9:0];
      CORNER_B: corner = tri_q[19:10];
      default:  corner = tri_q[29:20];
    endcase
  end
  assign corner_oob = ({22'd0, corner} >= 32'(MAX_VERTICES));

  // stores: written by item accepts, read during a query
  always_ff @(posedge clk) begin
    if (cmd.wr_vertex && ({22'd0, slot} < 32'(MAX_VERTICES)))
      vmem[VAW'(slot)] <= {coord_y, coord_x};
    if (cmd.wr_triangle && ({22'd0, slot} < 32'(MAX_TRIANGLES)))
      tmem[TAW'(slot)] <= {corner_c, corner_b, corner_a};
    if (cmd.tri_rd) tri_q <= tmem[tri_addr];
    if (cmd.vrd_en) begin
      vert_q <= vmem[VAW'(corner)];
      oob_q  <= corner_oob;
    end
  end

  // corner registers and query point
  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      px <= coord_x;
      py <= coord_y;
    end
    if (cmd.vlatch_en) begin
      case (cmd.vlatch_sel)
        CORNER_A: begin
          ax <= oob_q ? 32'sd0 : signed'(vert_q[31:0]);
          ay <= oob_q ? 32'sd0 : signed'(vert_q[63:32]);
        end
        CORNER_B: begin
          bx <= oob_q ? 32'sd0 : signed'(vert_q[31:0]);
          by <= oob_q ? 32'sd0 : signed'(vert_q[63:32]);
        end
        default: begin
          cx <= oob_q ? 32'sd0 : signed'(vert_q[31:0]);
          cy <= oob_q ? 32'sd0 : signed'(vert_q[63:32]);
        end
      endcase
    end
  end

  // operand pairs: even steps give ux*vy, odd steps uy*vx
  always_comb begin
    case (cmd.mul_step)
      3'd0:    begin d1 = dif(bx, ax); d2 = dif(cy, ay); end
      3'd1:    begin d1 = dif(by, ay); d2 = dif(cx, ax); end
      3'd2:    begin d1 = dif(bx, px); d2 = dif(cy, py); end
      3'd3:    begin d1 = dif(by, py); d2 = dif(cx, px); end
      3'd4:    begin d1 = dif(cx, px); d2 = dif(ay, py); end
      3'd5:    begin d1 = dif(cy, py); d2 = dif(ax, px); end
      3'd6:    begin d1 = dif(ax, px); d2 = dif(by, py); end
      default: begin d1 = dif(ay, py); d2 = dif(bx, px); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mul_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op1  <= d1;
    op2  <= d2;
    s1   <= cmd.mul_step;
    prod <= op1 * op2;
    s2   <= s1;
    if (v2) begin
      if (!s2[0]) acc <= {prod[65], prod};
      else        crs[s2[2:1]] <= acc - {prod[65], prod};
    end
    if (cmd.norm) begin
      for (int i = 0; i < 4; i++)
        nrm[i] <= crs[0][CROSS_W-1] ? -crs[i] : crs[i];
    end
  end

  // inside when the determinant is nonzero and every numerator lies in [0, det]
  assign sts.hit = (nrm[0] != '0)
                && !nrm[1][CROSS_W-1] && !nrm[2][CROSS_W-1] && !nrm[3][CROSS_W-1]
                && (nrm[0] >= nrm[1]) && (nrm[0] >= nrm[2]) && (nrm[0] >= nrm[3]);

  // restoring divider, one quotient bit a cycle
  always_comb begin
    case (cmd.div_sel)
      2'd0:    num = nrm[1];
      2'd1:    num = nrm[2];
      default: num = nrm[3];
    endcase
    rem_in  = cmd.div_first ? {1'b0, num} : {rem[CROSS_W-1:0], 1'b0};
    q_in    = cmd.div_first ? 18'd0 : {q[16:0], 1'b0};
    ge      = (rem_in >= {1'b0, nrm[0]});
    rem_sub = rem_in - {1'b0, nrm[0]};
    q_new   = q_in | {17'd0, ge};
    rsum    = {1'b0, q_new} + 19'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      rem <= ge ? rem_sub : rem_in;
      q   <= q_new;
    end
    if (cmd.clear) begin
      for (int i = 0; i < 3; i++) w[i] <= '0;
    end else if (cmd.div_en && cmd.div_last) begin
      case (cmd.div_sel)
        2'd0:    w[0] <= rsum[17:1];
        2'd1:    w[1] <= rsum[17:1];
        default: w[2] <= rsum[17:1];
      endcase
    end
  end

  assign weight_a = w[0];
  assign weight_b = w[1];
  assign weight_c = w[2];

endmodule

/* design/triangle_point_locator.sv */
// top level of the triangle point locator
// Usage: an item is taken when start is high and busy is low. mode selects a
// vertex write (slot, coord_x, coord_y), a triangle write (slot, corner_a..c)
// or a point query (coord_x, coord_y); mode 3 does nothing. Writes finish at
// the accepting edge and give no result, so busy stays low.
// A query raises busy and walks triangles 0 to triangle_count-1 in order,
// at most MAX_TRIANGLES of them, and stops at the first hit. Each triangle
// takes a triangle-store read, three vertex reads through the single
// vertex-store port, eight products through one shared 33x33 multiplier and
// a normalise and test step. On a hit the three weights come one after
// another from a restoring divider. busy stays high up to and including the
// cycle with done high.
// The result is shown for one cycle with done high; the receiver must take it
// then, as it cannot stall the block.
// triangle_count is written over the cfg channel while the block is idle.
// Reset clears the controller and the count; both stores hold nothing until
// written and need no clearing pass.
module triangle_point_locator #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [9:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data,
  output logic               done,
  output logic               found,
  output logic [9:0]         triangle_index,
  output logic [16:0]        weight_a,
  output logic [16:0]        weight_b,
  output logic [16:0]        weight_c
);
  import tpl_pkg::*;

  localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  cmd_t cmd;
  sts_t sts;
  logic [TAW-1:0] tri_addr;

  tpl_ctrl #(
    .MAX_TRIANGLES(MAX_TRIANGLES),
    .TAW(TAW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .mode(mode),
    .cfg_valid(cfg_valid),
    .cfg_data(cfg_data),
    .sts(sts),
    .cmd(cmd),
    .tri_addr(tri_addr),
    .busy(busy),
    .cfg_ready(cfg_ready),
    .done(done),
    .found(found),
    .triangle_index(triangle_index)
  );

  tpl_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_TRIANGLES(MAX_TRIANGLES),
    .TAW(TAW)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .tri_addr(tri_addr),
    .slot(slot),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .corner_a(corner_a),
    .corner_b(corner_b),
    .corner_c(corner_c),
    .sts(sts),
    .weight_a(weight_a),
    .weight_b(weight_b),
    .weight_c(weight_c)
  );

endmodule

/* verif/tpl_checker.sv */
// request and result checker with its own point locator for the triangle point locator
module tpl_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode,
  input  logic [9:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [10:0]        cfg_data,
  input  logic               done,
  input  logic               found,
  input  logic [9:0]         triangle_index,
  input  logic [16:0]        weight_a,
  input  logic [16:0]        weight_b,
  input  logic [16:0]        weight_c,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpl_pkg::*;

  typedef struct {
    logic        hit;
    logic [9:0]  idx;
    logic [16:0] wa;
    logic [16:0] wb;
    logic [16:0] wc;
  } answer_t;

  logic signed [31:0] vert_x [1024];
  logic signed [31:0] vert_y [1024];
  logic [9:0]         tri_ca [1024];
  logic [9:0]         tri_cb [1024];
  logic [9:0]         tri_cc [1024];
  logic [10:0]        search_len;
  answer_t            answers [$];

  function automatic logic signed [95:0] cross2(logic signed [95:0] ux, logic signed [95:0] uy,
                                                logic signed [95:0] vx, logic signed [95:0] vy);
    return ux * vy - uy * vx;
  endfunction

  // round(n * 2^16 / d), ties upward
  function automatic logic [16:0] to_q16(logic [95:0] n, logic [95:0] d);
    logic [127:0] q;
    q = ({32'b0, n} << 17) / {32'b0, d};
    q = (q + 128'd1) >> 1;
    return q[16:0];
  endfunction

  function automatic answer_t locate(logic signed [31:0] qx, logic signed [31:0] qy);
    answer_t r;
    int lim;
    logic signed [95:0] px, py, ax, ay, bx, by, cx, cy, d, na, nb, nc;
    r = '{hit: 1'b0, idx: '0, wa: '0, wb: '0, wc: '0};
    lim = (search_len > 11'd1024) ? 1024 : int'(search_len);
    px = 96'(qx);
    py = 96'(qy);
    for (int t = 0; t < lim; t++) begin
      ax = 96'(vert_x[tri_ca[t]]); ay = 96'(vert_y[tri_ca[t]]);
      bx = 96'(vert_x[tri_cb[t]]); by = 96'(vert_y[tri_cb[t]]);
      cx = 96'(vert_x[tri_cc[t]]); cy = 96'(vert_y[tri_cc[t]]);
      d = cross2(bx - ax, by - ay, cx - ax, cy - ay);
      if (d == 0) continue;
      na = cross2(bx - px, by - py, cx - px, cy - py);
      nb = cross2(cx - px, cy - py, ax - px, ay - py);
      nc = cross2(ax - px, ay - py, bx - px, by - py);
      if (d < 0) begin
        d = -d; na = -na; nb = -nb; nc = -nc;
      end
      if (na < 0 || nb < 0 || nc < 0) continue;
      if (na > d || nb > d || nc > d) continue;
      r.hit = 1'b1;
      r.idx = t[9:0];
      r.wa = to_q16(na, d);
      r.wb = to_q16(nb, d);
      r.wc = to_q16(nc, d);
      break;
    end
    return r;
  endfunction

  assign pending = answers.size();

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      search_len <= '0;
      answers.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) search_len <= cfg_data;
      if (start && !busy) begin
        case (mode)
          MODE_VERTEX: begin
            vert_x[slot] = coord_x;
            vert_y[slot] = coord_y;
          end
          MODE_TRIANGLE: begin
            tri_ca[slot] = corner_a;
            tri_cb[slot] = corner_b;
            tri_cc[slot] = corner_c;
          end
          MODE_QUERY: answers = {answers, locate(coord_x, coord_y)};
          default: ;
        endcase
      end
      if (done) begin
        if (answers.size() == 0) begin
          if (fail_count < 10) $display("unexpected result at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          e = answers.pop_front();
          if (found !== e.hit || triangle_index !== e.idx || weight_a !== e.wa ||
              weight_b !== e.wb || weight_c !== e.wc) begin
            if (fail_count < 10)
              $display("mismatch at %0t: exp %b %0d %0d %0d %0d got %b %0d %0d %0d %0d",
                       $realtime, e.hit, e.idx, e.wa, e.wb, e.wc,
                       found, triangle_index, weight_a, weight_b, weight_c);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* verif/tb.sv */
// top of the triangle point locator testbench: stimulus, watchdog and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpl_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int STALL_LIMIT = 100000;

  logic               clk, rst, start, busy, cfg_valid, cfg_ready, done, found;
  logic [1:0]         mode;
  logic [9:0]         slot, corner_a, corner_b, corner_c, triangle_index;
  logic signed [31:0] coord_x, coord_y;
  logic [10:0]        cfg_data;
  logic [16:0]        weight_a, weight_b, weight_c;
  int                 fail_count, pending, idle_cycles;

  triangle_point_locator dut (.*);
  tpl_checker chk (.*);

  // what has been written so far, so that only written entries are ever read
  longint     vx [1024];
  longint     vy [1024];
  bit         vknown [1024];
  int         vlist [$];
  int         ta [1024];
  int         tbc [1024];
  int         tc [1024];
  int         tri_n, count_now, burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(logic [1:0] m, int s, longint x, longint y, int a, int b, int c);
    mode = m; slot = 10'(s); coord_x = 32'(x); coord_y = 32'(y);
    corner_a = 10'(a); corner_b = 10'(b); corner_c = 10'(c);
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
    end
  endtask

  task automatic put_vertex(int s, longint x, longint y);
    vx[s] = longint'(signed'(32'(x)));
    vy[s] = longint'(signed'(32'(y)));
    if (!vknown[s]) vlist = {vlist, s};
    vknown[s] = 1'b1;
    issue(MODE_VERTEX, s, x, y, $urandom_range(0, 1023), $urandom_range(0, 1023),
          $urandom_range(0, 1023));
  endtask

  task automatic put_triangle(int s, int a, int b, int c);
    ta[s] = a; tbc[s] = b; tc[s] = c;
    if (s == tri_n) tri_n++;
    issue(MODE_TRIANGLE, s, longint'($urandom), longint'($urandom), a, b, c);
  endtask

  task automatic ask(longint x, longint y);
    issue(MODE_QUERY, $urandom_range(0, 1023), x, y, $urandom_range(0, 1023),
          $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic set_count(int v);
    settle();
    cfg_data = 11'(v);
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
    count_now = v;
  endtask

  function automatic longint any_coord();
    if ($urandom_range(0, 3) == 0) return longint'(signed'($urandom));
    return longint'($urandom_range(0, 2 ** 22)) - 2 ** 21;
  endfunction

  function automatic int any_vertex();
    return vlist[$urandom_range(0, vlist.size() - 1)];
  endfunction

  task automatic random_triangle(int s);
    int a, b, c;
    a = any_vertex(); b = any_vertex(); c = any_vertex();
    if ($urandom_range(0, 9) == 0) c = b;
    put_triangle(s, a, b, c);
  endtask

  // a point inside or on the edge of a written triangle, up to rounding
  task automatic ask_inside();
    int t, r1, r2;
    longint px, py;
    t = (count_now > 0 && $urandom_range(0, 3) != 0)
        ? $urandom_range(0, (count_now > tri_n ? tri_n : count_now) - 1)
        : $urandom_range(0, tri_n - 1);
    r1 = $urandom_range(0, 256);
    r2 = $urandom_range(0, 256 - r1);
    px = vx[ta[t]] + ((vx[tbc[t]] - vx[ta[t]]) * r1 + (vx[tc[t]] - vx[ta[t]]) * r2) / 256;
    py = vy[ta[t]] + ((vy[tbc[t]] - vy[ta[t]]) * r1 + (vy[tc[t]] - vy[ta[t]]) * r2) / 256;
    ask(px, py);
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    mode = '0; slot = '0; coord_x = '0; coord_y = '0;
    corner_a = '0; corner_b = '0; corner_c = '0;
    tri_n = 0; count_now = 0; burst_left = 4;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty search, corners, degenerate, both windings, extremes
    set_count(0);
    ask(0, 0);
    put_vertex(0, 0, 0);
    put_vertex(1, 10 << 16, 0);
    put_vertex(2, 0, 10 << 16);
    put_vertex(1023, 32'h7FFF_FFFF, 32'h8000_0000);
    put_vertex(1022, 32'h8000_0000, 32'h7FFF_FFFF);
    put_vertex(1021, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_triangle(0, 0, 1, 1);
    put_triangle(1, 0, 1, 2);
    put_triangle(2, 0, 2, 1);
    put_triangle(3, 1023, 1022, 1021);
    set_count(4);
    ask(1 << 16, 1 << 16);
    ask(0, 0);
    ask(10 << 16, 0);
    ask(5 << 16, 5 << 16);
    ask(20 << 16, 20 << 16);
    ask(32'h7FFF_FFFF, 32'h8000_0000);
    ask(32'h8000_0000, 32'h8000_0000);
    ask(-(1 << 16), 1 << 16);
    issue(MODE_NONE, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1023, 1023, 1023);
    set_count(3);
    ask(2 << 16, 3 << 16);

    // random: mixed writes and queries, count changed now and then
    for (int i = 0; i < 250; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (i % 50 == 49) begin
        case ($urandom_range(0, 3))
          0: set_count(0);
          1: set_count(1);
          2: set_count(tri_n);
          default: set_count($urandom_range(1, tri_n));
        endcase
      end
      if (pick < 28) put_vertex($urandom_range(0, 1023), any_coord(), any_coord());
      else if (pick < 48)
        random_triangle(($urandom_range(0, 2) == 0) ? $urandom_range(0, tri_n - 1) : tri_n);
      else if (pick < 95) begin
        if ($urandom_range(0, 9) < 6) ask_inside();
        else ask(any_coord(), any_coord());
      end else issue(MODE_NONE, $urandom_range(0, 1023), longint'($urandom),
                     longint'($urandom), $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
    end

    // count at the top of its range, answered by the first triangle; then more queries
    put_vertex(0, 0, 0);
    put_vertex(1, 10 << 16, 0);
    put_vertex(2, 0, 10 << 16);
    put_triangle(0, 0, 1, 2);
    set_count(2047);
    ask(1 << 16, 1 << 16);
    ask(0, 0);
    set_count(tri_n);
    repeat (3) ask_inside();
    ask(32'h8000_0000, 32'h7FFF_FFFF);

    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

/* files.f */
design/tpl_pkg.sv
design/tpl_ctrl.sv
design/tpl_datapath.sv
design/triangle_point_locator.sv
verif/tpl_checker.sv
verif/tb.sv
